>>> rtl/core/sfr_pkg.sv
// Shared types, constants and frame decode for the status frame receiver.
package sfr_pkg;

	localparam logic [7:0] HEADER_CODE = 8'h55;
	localparam logic [7:0] LIMIT_RESET = 8'd5;
	localparam logic [1:0] LAST_POS    = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BAD_HDR = 2'd1;
	localparam logic [1:0] ST_BAD_SUM = 2'd2;

	localparam logic FUNC_BYTE = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	typedef struct packed {
		logic       func;
		logic [7:0] rx_byte;
	} sfr_item_t;

	typedef struct packed {
		logic [1:0] frame_status;
		logic [1:0] warm_level;
		logic [1:0] cool_level;
		logic       power_on;
		logic [2:0] humidify_level;
		logic [2:0] timer_code;
	} sfr_result_t;

	function automatic sfr_result_t decode_frame(logic [7:0] b0, logic [7:0] b1,
			logic [7:0] b2, logic [7:0] b3);
		sfr_result_t r;
		r = '0;
		if (b0 != HEADER_CODE) begin
			r.frame_status = ST_BAD_HDR;
		end else if ((b0 ^ b1 ^ b2) != b3) begin
			r.frame_status = ST_BAD_SUM;
		end else begin
			r.frame_status   = ST_OK;
			// byte2 bit5 picks which light channel gets the level
			r.warm_level     = b2[5] ? b1[2:1] : 2'd0;
			r.cool_level     = b2[5] ? 2'd0 : b1[2:1];
			r.power_on       = b1[3];
			r.humidify_level = b1[6:4];
			r.timer_code     = b2[2:0];
		end
		return r;
	endfunction

endpackage

>>> rtl/core/sfr_item_if.sv
// Input channel: one received byte or idle tick per transaction.
interface sfr_item_if;
	import sfr_pkg::*;

	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] rx_byte;

	modport source (output valid, output func, output rx_byte, input ready);
	modport sink (input valid, input func, input rx_byte, output ready);
endinterface

>>> rtl/core/sfr_result_if.sv
// Output channel: one decoded frame report per transaction.
interface sfr_result_if;
	import sfr_pkg::*;

	logic       valid;
	logic       ready;
	logic [1:0] frame_status;
	logic [1:0] warm_level;
	logic [1:0] cool_level;
	logic       power_on;
	logic [2:0] humidify_level;
	logic [2:0] timer_code;

	modport source (output valid, output frame_status, output warm_level,
		output cool_level, output power_on, output humidify_level,
		output timer_code, input ready);
	modport sink (input valid, input frame_status, input warm_level,
		input cool_level, input power_on, input humidify_level,
		input timer_code, output ready);
endinterface

>>> rtl/core/sfr_in_stage.sv
// Input register stage: captures one transaction and holds it until consumed.
module sfr_in_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  sfr_pkg::sfr_item_t  in_item,
	input  logic                take,
	output logic                valid_s1,
	output sfr_pkg::sfr_item_t  item_s1
);
	import sfr_pkg::*;

	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end
endmodule

>>> rtl/core/sfr_frame_core.sv
// Frame assembly state, idle timeout, frame check and result register.
module sfr_frame_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [7:0]           idle_limit,
	input  logic                 valid_s1,
	input  sfr_pkg::sfr_item_t   item_s1,
	output logic                 take,
	output logic                 res_valid,
	input  logic                 res_ready,
	output sfr_pkg::sfr_result_t res_data
);
	import sfr_pkg::*;

	logic [1:0]  byte_index_q;
	logic [7:0]  silence_count_q;
	logic        byte_seen_q;
	logic [7:0]  frame_store_q [3];
	logic        res_valid_q;
	sfr_result_t res_q;

	logic        completes;
	logic        out_free;
	logic [7:0]  silence_inc;

	assign completes   = (item_s1.func == FUNC_BYTE) && (byte_index_q == LAST_POS);
	assign out_free    = !res_valid_q || res_ready;
	// only a frame-completing byte needs room in the result register
	assign take        = valid_s1 && (!completes || out_free);
	assign silence_inc = silence_count_q + 8'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q    <= '0;
			silence_count_q <= '0;
			byte_seen_q     <= 1'b0;
		end else if (take) begin
			if (item_s1.func == FUNC_TICK) begin
				if (byte_seen_q) begin
					byte_seen_q     <= 1'b0;
					silence_count_q <= '0;
				end else if (silence_inc > idle_limit) begin
					silence_count_q <= '0;
					byte_index_q    <= '0;
				end else begin
					silence_count_q <= silence_inc;
				end
			end else begin
				byte_seen_q  <= 1'b1;
				byte_index_q <= byte_index_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && item_s1.func == FUNC_BYTE && !completes) begin
			frame_store_q[byte_index_q] <= item_s1.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take && completes) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && completes) begin
			res_q <= decode_frame(frame_store_q[0], frame_store_q[1],
				frame_store_q[2], item_s1.rx_byte);
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

`ifndef SYNTH
	a_tick_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(take && item_s1.func == FUNC_TICK) |=> !$rose(res_valid_q))
		else $error("tick produced a result");
	a_index_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		(take && completes) |=> (byte_index_q == 2'd0))
		else $error("frame position not restarted after fourth byte");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_ready) |=> ($stable(res_q) && res_valid_q))
		else $error("pending result overwritten");
	a_bad_zeroed: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.frame_status != ST_OK) |->
		(res_q.warm_level == 2'd0 && res_q.cool_level == 2'd0 &&
		res_q.power_on == 1'b0 && res_q.humidify_level == 3'd0 &&
		res_q.timer_code == 3'd0))
		else $error("bad frame carries nonzero fields");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (res_q.frame_status != 2'd3))
		else $error("undefined frame status");
	a_one_light: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (res_q.warm_level == 2'd0 || res_q.cool_level == 2'd0))
		else $error("both light channels driven");
`endif
endmodule

>>> rtl/core/status_frame_receiver.sv
// Top level of the status frame receiver.
// Gathers received bytes into four-byte frames (header 0x55, byte3 = XOR of
// bytes 0..2) and reports each complete frame as one result: status plus the
// decoded light level, power, humidify strength and timer code; a bad frame
// reports its status with all other fields zero. Tick transactions measure
// silence: after more than idle_limit ticks with no byte in between, a partial
// frame is dropped. One transaction is accepted every cycle unless a
// frame-completing byte finds the result register full, the only stall; the
// fourth byte passes the input register, then the result register. idle_limit
// resets to 5; the user writes it only while idle, not enforced by the block.
module status_frame_receiver (
	input  logic         clk,
	input  logic         arst_n,
	sfr_item_if.sink     item,
	sfr_result_if.source result,
	input  logic         cfg_we,
	input  logic [7:0]   cfg_wdata
);
	import sfr_pkg::*;

	logic        idle_limit_q;
	logic [7:0]  idle_limit_val_q;
	sfr_item_t   in_item;
	sfr_item_t   item_s1;
	logic        valid_s1;
	logic        take;
	sfr_result_t res_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_limit_val_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			idle_limit_val_q <= cfg_wdata;
		end
	end

	// marks that the limit register has been written at least once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_limit_q <= 1'b0;
		end else if (cfg_we) begin
			idle_limit_q <= 1'b1;
		end
	end

	assign in_item.func    = item.func;
	assign in_item.rx_byte = item.rx_byte;

	sfr_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (item.ready),
		.in_item  (in_item),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	sfr_frame_core u_frame_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.idle_limit (idle_limit_val_q),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1),
		.take       (take),
		.res_valid  (result.valid),
		.res_ready  (result.ready),
		.res_data   (res_data)
	);

	assign result.frame_status   = res_data.frame_status;
	assign result.warm_level     = res_data.warm_level;
	assign result.cool_level     = res_data.cool_level;
	assign result.power_on       = res_data.power_on;
	assign result.humidify_level = res_data.humidify_level;
	assign result.timer_code     = res_data.timer_code;

`ifndef SYNTH
	a_cfg_tracked: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> (idle_limit_q && idle_limit_val_q == $past(cfg_wdata)))
		else $error("idle limit write lost");
	a_limit_reset: assert property (@(posedge clk) disable iff (!arst_n)
		!idle_limit_q |-> (idle_limit_val_q == LIMIT_RESET))
		else $error("idle limit changed without a write");
	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !take) |=> (valid_s1 && $stable(item_s1)))
		else $error("stalled input stage changed");
`endif
endmodule
